// ----- hdl/chimp_pkg.sv -----
// Shared types, constants and bit-scan helpers for the Chimp128 float encoder.
// No dependencies.
package chimp_pkg;

    localparam int DEF_HASH_BITS = 14;
    localparam int RING_DEPTH    = 128;
    localparam int RING_AW       = 7;
    localparam int EPOCH_BITS    = 8;
    localparam int OQ_DEPTH      = 8;
    localparam int OQ_AW         = 3;

    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX  = '1;
    localparam logic [6:0]            NONE_LEAD  = 7'd65;
    localparam logic [6:0]            STRIP_MIN  = 7'd7;

    localparam logic [2:0] FLAG_RING_NEW   = 3'd1;
    localparam logic [2:0] FLAG_RING_REUSE = 3'd2;
    localparam logic [2:0] FLAG_NEW        = 3'd3;
    localparam logic [2:0] FLAG_STRIP      = 3'd5;
    localparam logic [2:0] FLAG_REUSE      = 3'd6;

    localparam logic [6:0] LEAD_TAB [8] = '{7'd0, 7'd8, 7'd12, 7'd16,
                                            7'd18, 7'd20, 7'd22, 7'd24};

    typedef struct packed {
        logic [63:0] value;
        logic        start_req;
    } in_t;

    typedef struct packed {
        logic [63:0] chunk;
        logic [6:0]  chunk_len;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic                  vld;
        logic [RING_AW-1:0]    slot;
    } map_entry_t;

    function automatic logic [6:0] clz64(input logic [63:0] x);
        logic [63:0] t;
        logic [6:0]  n;
        begin
            t = x;
            n = 7'd0;
            if (t[63:32] == 32'd0) begin n = n + 7'd32; t = t << 32; end
            if (t[63:48] == 16'd0) begin n = n + 7'd16; t = t << 16; end
            if (t[63:56] == 8'd0)  begin n = n + 7'd8;  t = t << 8;  end
            if (t[63:60] == 4'd0)  begin n = n + 7'd4;  t = t << 4;  end
            if (t[63:62] == 2'd0)  begin n = n + 7'd2;  t = t << 2;  end
            if (t[63] == 1'b0)     begin n = n + 7'd1;  end
            if (x == 64'd0) n = 7'd64;
            return n;
        end
    endfunction

    function automatic logic [6:0] ctz64(input logic [63:0] x);
        logic [63:0] t;
        logic [6:0]  n;
        begin
            t = x;
            n = 7'd0;
            if (t[31:0] == 32'd0) begin n = n + 7'd32; t = t >> 32; end
            if (t[15:0] == 16'd0) begin n = n + 7'd16; t = t >> 16; end
            if (t[7:0] == 8'd0)   begin n = n + 7'd8;  t = t >> 8;  end
            if (t[3:0] == 4'd0)   begin n = n + 7'd4;  t = t >> 4;  end
            if (t[1:0] == 2'd0)   begin n = n + 7'd2;  t = t >> 2;  end
            if (t[0] == 1'b0)     begin n = n + 7'd1;  end
            if (x == 64'd0) n = 7'd64;
            return n;
        end
    endfunction

    function automatic logic [2:0] round_code(input logic [6:0] clz);
        logic [2:0] code;
        begin
            code = 3'd0;
            for (int k = 1; k < 8; k++) begin
                if (LEAD_TAB[k] <= clz) code = 3'(k);
            end
            return code;
        end
    endfunction

    function automatic logic [63:0] mask_low(input logic [63:0] d, input logic [6:0] len);
        logic [63:0] m;
        begin
            m = (len >= 7'd64) ? '1 : ((64'd1 << len) - 64'd1);
            return d & m;
        end
    endfunction

endpackage

// ----- hdl/chimp_map.sv -----
// Hash index map memory with a clearing sweep after reset or on request.
// Depends on chimp_pkg.
module chimp_map #(
    parameter int HASH_BITS = chimp_pkg::DEF_HASH_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [HASH_BITS-1:0]        rd_addr,
    output chimp_pkg::map_entry_t       rd_data,
    input  logic                        wr_en,
    input  logic [HASH_BITS-1:0]        wr_addr,
    input  chimp_pkg::map_entry_t       wr_data,
    input  logic                        clr_req,
    output logic                        busy
);
    import chimp_pkg::*;

    map_entry_t           map_mem [2**HASH_BITS];
    map_entry_t           rd_data_reg;
    logic                 clearing_reg;
    logic [HASH_BITS-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == '1)
                clearing_reg <= 1'b0;
        end
        else if (clr_req)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            map_mem[clr_idx_reg] <= '0;
        else if (wr_en)
            map_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= map_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// ----- hdl/chimp_ring.sv -----
// History ring memory: one write and one registered read port.
// Depends on chimp_pkg.
module chimp_ring (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [chimp_pkg::RING_AW-1:0] rd_addr,
    output logic [63:0]                   rd_data,
    input  logic                          wr_en,
    input  logic [chimp_pkg::RING_AW-1:0] wr_addr,
    input  logic [63:0]                   wr_data
);
    import chimp_pkg::*;

    logic [63:0] ring_mem [RING_DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= ring_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/chimp_oq.sv -----
// Chunk queue; takes one or two chunks per push, gives one per cycle unless stalled.
// Depends on chimp_pkg.
module chimp_oq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_en,
    input  logic                        push_two,
    input  chimp_pkg::out_t             push_a,
    input  chimp_pkg::out_t             push_b,
    output chimp_pkg::out_t             result,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [chimp_pkg::OQ_AW:0]   count
);
    import chimp_pkg::*;

    out_t             q_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_AW:0]   count_reg, count_next;
    logic [OQ_AW:0]   push_n;
    logic             pop;

    assign result_valid = (count_reg != '0);
    assign result       = q_mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    assign count        = count_reg;

    always_comb
    begin
        push_n      = push_en ? (push_two ? (OQ_AW+1)'(2) : (OQ_AW+1)'(1)) : '0;
        wr_ptr_next = wr_ptr_reg + push_n[OQ_AW-1:0];
        rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
        count_next  = count_reg + push_n - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_mem[wr_ptr_reg] <= push_a;
            if (push_two)
                q_mem[wr_ptr_reg + OQ_AW'(1)] <= push_b;
        end
    end

endmodule

// ----- hdl/chimp128_float_encoder.sv -----
// Chimp128 float encoder top level: lookup pipeline, coding logic and state update.
// Depends on chimp_pkg, chimp_map, chimp_ring and chimp_oq.
//
// Usage: each sample transaction carries one 64-bit double and start_req, which
// opens a new column. Each sample yields one or two chunk transactions on the
// result channel (LSB-first bits, chunk_len valid bits, last on the final one).
// Pipeline: a sample goes through hash map read, ring read and coding; its chunks
// are then pushed into the registered output queue. A new sample is not taken
// while the previous one is in its map read, which the dependent ring read needs.
// Reset clears control state and sweeps every hash map entry, stalling the
// sample channel. A start sample that exhausts the 8-bit column epoch waits for
// such a sweep. An 8-entry output queue holds chunks while the receiver stalls;
// samples stall once it cannot take two more past those of the sample in coding.
module chimp128_float_encoder #(
    parameter int HASH_BITS = chimp_pkg::DEF_HASH_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  chimp_pkg::in_t    sample,
    input  logic              sample_valid,
    output logic              sample_stall,
    output chimp_pkg::out_t   result,
    output logic              result_valid,
    input  logic              result_stall
);
    import chimp_pkg::*;

    logic                  s1_valid_reg, s2_valid_reg;
    logic [63:0]           s1_value_reg, s2_value_reg;
    logic                  s1_start_reg, s2_start_reg;
    logic                  s2_hit_reg;
    logic [RING_AW-1:0]    s2_slot_reg;
    logic [63:0]           prev_value_reg;
    logic [6:0]            prev_lead_reg, prev_lead_next;
    logic [RING_AW-1:0]    wpos_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic                  fwd_valid_reg;
    logic [HASH_BITS-1:0]  fwd_hash_reg;
    map_entry_t            fwd_entry_reg;

    logic                  accept, wrap_block, clr_req, map_busy, space;
    logic [OQ_AW:0]        oq_count;
    map_entry_t            map_rdata, s1_entry, wr_entry;
    logic                  s1_hit;
    logic [63:0]           ring_rdata;
    logic [HASH_BITS-1:0]  s1_hash, s2_hash;
    logic [RING_AW-1:0]    wpos_use;
    logic [EPOCH_BITS-1:0] epoch_new;
    out_t                  res_a, res_b;
    logic                  res_two;

    assign wrap_block = sample.start_req && (epoch_reg >= EPOCH_MAX - 1'b1);
    assign space = ({1'b0, oq_count} + (s2_valid_reg ? (OQ_AW+2)'(2) : '0) + (OQ_AW+2)'(2))
                   <= (OQ_AW+2)'(OQ_DEPTH);
    assign sample_stall = map_busy || s1_valid_reg || !space || wrap_block;
    assign accept  = sample_valid && !sample_stall;
    assign clr_req = sample_valid && wrap_block && !map_busy
                     && !s1_valid_reg && !s2_valid_reg;

    assign s1_hash  = s1_value_reg[63 -: HASH_BITS];
    assign s2_hash  = s2_value_reg[63 -: HASH_BITS];
    assign s1_entry = (fwd_valid_reg && fwd_hash_reg == s1_hash) ? fwd_entry_reg : map_rdata;
    assign s1_hit   = s1_entry.vld && (s1_entry.epoch == epoch_reg);

    assign wpos_use  = s2_start_reg ? '0 : wpos_reg;
    assign epoch_new = s2_start_reg ? epoch_reg + 1'b1 : epoch_reg;
    assign wr_entry  = '{epoch: epoch_new, vld: 1'b1, slot: wpos_use};

    chimp_map #(.HASH_BITS(HASH_BITS)) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (sample.value[63 -: HASH_BITS]),
        .rd_data (map_rdata),
        .wr_en   (s2_valid_reg),
        .wr_addr (s2_hash),
        .wr_data (wr_entry),
        .clr_req (clr_req),
        .busy    (map_busy)
    );

    chimp_ring u_ring (
        .clk     (clk),
        .rd_en   (s1_valid_reg),
        .rd_addr (s1_entry.slot),
        .rd_data (ring_rdata),
        .wr_en   (s2_valid_reg),
        .wr_addr (wpos_use),
        .wr_data (s2_value_reg)
    );

    chimp_oq u_oq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_en      (s2_valid_reg),
        .push_two     (res_two),
        .push_a       (res_a),
        .push_b       (res_b),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .count        (oq_count)
    );

    logic [63:0] xp, xr;
    logic [2:0]  cp, cr;
    logic [6:0]  lp, lr, tp, tr, sig_r, sig;
    logic [7:0]  lp8, tp8, pl8, bp, br, new_r, c_strip, c_new, c_re;
    logic        re_p, re_r, ring_win, strip_r;
    logic [2:0]  flag;

    always_comb
    begin
        xp   = s2_value_reg ^ prev_value_reg;
        xr   = s2_value_reg ^ ring_rdata;
        cp   = round_code(clz64(xp));
        cr   = round_code(clz64(xr));
        lp   = LEAD_TAB[cp];
        lr   = LEAD_TAB[cr];
        tp   = ctz64(xp);
        tr   = ctz64(xr);
        lp8  = {1'b0, lp};
        tp8  = {1'b0, tp};
        pl8  = {1'b0, prev_lead_reg};
        re_p = (prev_lead_reg != NONE_LEAD) && (lp == prev_lead_reg);
        re_r = (prev_lead_reg != NONE_LEAD) && (lr == prev_lead_reg);

        c_new   = 8'd70 - lp8;
        c_strip = 8'd76 - lp8 - tp8;
        c_re    = re_p ? 8'd67 - pl8 : 8'hFF;
        bp = c_new;
        if (tp >= STRIP_MIN && c_strip < bp)
            bp = c_strip;
        if (re_p && c_re < bp)
            bp = c_re;

        strip_r = (tr >= STRIP_MIN);
        sig_r   = strip_r ? 7'd64 - lr - tr : 7'd64 - lr;
        new_r   = 8'd19 + {1'b0, sig_r};
        br = new_r;
        if (re_r && 8'd74 - pl8 < br)
            br = 8'd74 - pl8;
        ring_win = s2_hit_reg && (xr != 64'd0) && (br < bp);

        if (tp >= STRIP_MIN)
        begin
            if (c_strip <= c_new && c_strip <= c_re)
                flag = FLAG_STRIP;
            else if (re_p && c_re < c_new)
                flag = FLAG_REUSE;
            else
                flag = FLAG_NEW;
        end
        else
            flag = re_p ? FLAG_REUSE : FLAG_NEW;

        res_a          = '0;
        res_b          = '0;
        res_b.last     = 1'b1;
        res_two        = 1'b1;
        prev_lead_next = prev_lead_reg;
        sig            = 7'd0;

        if (s2_start_reg)
        begin
            res_a.chunk     = s2_value_reg;
            res_a.chunk_len = 7'd64;
            res_a.last      = 1'b1;
            res_two         = 1'b0;
            prev_lead_next  = NONE_LEAD;
        end
        else if (xp == 64'd0)
        begin
            res_a.chunk_len = 7'd2;
            res_a.last      = 1'b1;
            res_two         = 1'b0;
            prev_lead_next  = NONE_LEAD;
        end
        else if (ring_win)
        begin
            if (re_r && (8'd74 - pl8) <= new_r)
            begin
                res_a.chunk     = 64'(FLAG_RING_REUSE) | (64'(s2_slot_reg) << 3);
                res_a.chunk_len = 7'd10;
                sig             = 7'd64 - prev_lead_reg;
                res_b.chunk     = mask_low(xr, sig);
            end
            else
            begin
                sig             = sig_r;
                res_a.chunk     = 64'(FLAG_RING_NEW) | (64'(s2_slot_reg) << 3)
                                  | (64'(cr) << 10) | (64'(sig[5:0]) << 13);
                res_a.chunk_len = 7'd19;
                res_b.chunk     = mask_low(xr >> (strip_r ? tr : 7'd0), sig);
                prev_lead_next  = lr;
            end
            res_b.chunk_len = sig;
        end
        else
        begin
            case (flag)
                FLAG_STRIP:
                begin
                    sig             = 7'd64 - lp - tp;
                    res_a.chunk     = 64'(FLAG_STRIP) | (64'(cp) << 3) | (64'(sig[5:0]) << 6);
                    res_a.chunk_len = 7'd12;
                    res_b.chunk     = mask_low(xp >> tp, sig);
                    prev_lead_next  = lp;
                end
                FLAG_REUSE:
                begin
                    sig             = 7'd64 - prev_lead_reg;
                    res_a.chunk     = 64'(FLAG_REUSE);
                    res_a.chunk_len = 7'd3;
                    res_b.chunk     = mask_low(xp, sig);
                end
                default:
                begin
                    sig             = 7'd64 - lp;
                    res_a.chunk     = 64'(FLAG_NEW) | (64'(cp) << 3);
                    res_a.chunk_len = 7'd6;
                    res_b.chunk     = mask_low(xp, sig);
                    prev_lead_next  = lp;
                end
            endcase
            res_b.chunk_len = sig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            prev_value_reg <= '0;
            prev_lead_reg  <= NONE_LEAD;
            wpos_reg       <= '0;
            epoch_reg      <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (clr_req)
            begin
                epoch_reg     <= '0;
                fwd_valid_reg <= 1'b0;
            end
            else if (s2_valid_reg)
            begin
                epoch_reg      <= epoch_new;
                fwd_valid_reg  <= 1'b1;
                prev_value_reg <= s2_value_reg;
                prev_lead_reg  <= prev_lead_next;
                wpos_reg       <= wpos_use + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= sample.value;
            s1_start_reg <= sample.start_req;
        end
        if (s1_valid_reg)
        begin
            s2_value_reg <= s1_value_reg;
            s2_start_reg <= s1_start_reg;
            s2_hit_reg   <= s1_hit;
            s2_slot_reg  <= s1_entry.slot;
        end
        if (s2_valid_reg)
        begin
            fwd_hash_reg  <= s2_hash;
            fwd_entry_reg <= wr_entry;
        end
    end

endmodule

// ----- tb/chimp128_float_encoder_checker.sv -----
// Checker for the Chimp128 float encoder: watches both channels, predicts chunks, compares.
// Depends on chimp_pkg.
`timescale 1ns / 100ps
module chimp128_float_encoder_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  chimp_pkg::in_t  sample,
    input  logic            sample_valid,
    input  logic            sample_stall,
    input  chimp_pkg::out_t result,
    input  logic            result_valid,
    input  logic            result_stall,
    output int              errors,
    output int              pending,
    output int              chunk_count
);
    import chimp_pkg::*;

    localparam int HB = DEF_HASH_BITS;

    out_t        chunk_queue[$];
    logic [63:0] last_value;
    logic [6:0]  last_lead;
    logic [63:0] ring_mem [RING_DEPTH];
    logic [7:0]  slot_map [1 << HB];
    logic [6:0]  ring_pos;

    assign pending = chunk_queue.size();

    function automatic int lead_zeros(logic [63:0] x);
        for (int i = 63; i >= 0; i--)
            if (x[i]) return 63 - i;
        return 64;
    endfunction

    function automatic int trail_zeros(logic [63:0] x);
        for (int i = 0; i < 64; i++)
            if (x[i]) return i;
        return 64;
    endfunction

    function automatic int lead_code(int clz);
        int k;
        k = 7;
        while (k > 0 && int'(LEAD_TAB[k]) > clz) k--;
        return k;
    endfunction

    function automatic bit reusable(int lead);
        return last_lead != NONE_LEAD && lead == int'(last_lead);
    endfunction

    function automatic int prev_cost(logic [63:0] x);
        int lead, tz, best;
        lead = int'(LEAD_TAB[lead_code(lead_zeros(x))]);
        tz = trail_zeros(x);
        best = 6 + 64 - lead;
        if (tz >= STRIP_MIN && 12 + 64 - lead - tz < best) best = 12 + 64 - lead - tz;
        if (reusable(lead) && 3 + 64 - int'(last_lead) < best) best = 3 + 64 - int'(last_lead);
        return best;
    endfunction

    function automatic int ring_fresh_cost(int lead, int tz);
        return 19 + (tz >= STRIP_MIN ? 64 - lead - tz : 64 - lead);
    endfunction

    function automatic int ring_cost(logic [63:0] x);
        int lead, best;
        lead = int'(LEAD_TAB[lead_code(lead_zeros(x))]);
        best = ring_fresh_cost(lead, trail_zeros(x));
        if (reusable(lead) && 10 + 64 - int'(last_lead) < best) best = 10 + 64 - int'(last_lead);
        return best;
    endfunction

    task automatic push_chunk(logic [63:0] c, int len, bit fin);
        out_t o;
        logic [63:0] m;
        m = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
        o.chunk = c & m;
        o.chunk_len = 7'(len);
        o.last = fin;
        chunk_queue.push_back(o);
    endtask

    task automatic ring_insert(logic [63:0] v);
        ring_mem[ring_pos] = v;
        slot_map[v[63 -: HB]] = {1'b1, ring_pos};
        ring_pos = ring_pos + 7'd1;
    endtask

    task automatic clear_history();
        last_value = '0;
        last_lead = NONE_LEAD;
        ring_pos = '0;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        foreach (slot_map[i]) slot_map[i] = '0;
    endtask

    task automatic encode_sample(in_t s);
        logic [63:0] v, xp, xr;
        logic [7:0]  m;
        int slot, code, lead, tz, shift, sig, cs, cn, cr, flag;
        bit via_ring, re;
        v = s.value;
        xr = '0;
        slot = 0;
        via_ring = 0;
        if (s.start_req)
        begin
            clear_history();
            push_chunk(v, 64, 1);
            last_value = v;
            ring_insert(v);
            return;
        end
        xp = v ^ last_value;
        if (xp == 0)
        begin
            push_chunk('0, 2, 1);
            last_lead = NONE_LEAD;
            ring_insert(v);
            return;
        end
        m = slot_map[v[63 -: HB]];
        if (m[7])
        begin
            slot = int'(m[6:0]);
            xr = v ^ ring_mem[slot];
            if (xr != 0 && ring_cost(xr) < prev_cost(xp)) via_ring = 1;
        end
        if (via_ring)
        begin
            code = lead_code(lead_zeros(xr));
            lead = int'(LEAD_TAB[code]);
            tz = trail_zeros(xr);
            if (reusable(lead) && 10 + 64 - int'(last_lead) <= ring_fresh_cost(lead, tz))
            begin
                push_chunk(64'(FLAG_RING_REUSE) | (64'(slot) << 3), 10, 0);
                push_chunk(xr, 64 - int'(last_lead), 1);
            end
            else
            begin
                shift = tz >= STRIP_MIN ? tz : 0;
                sig = 64 - lead - shift;
                push_chunk(64'(FLAG_RING_NEW) | (64'(slot) << 3) | (64'(code) << 10)
                           | (64'(sig & 63) << 13), 19, 0);
                push_chunk(xr >> shift, sig, 1);
                last_lead = 7'(lead);
            end
        end
        else
        begin
            code = lead_code(lead_zeros(xp));
            lead = int'(LEAD_TAB[code]);
            tz = trail_zeros(xp);
            re = reusable(lead);
            if (tz >= STRIP_MIN)
            begin
                cs = 12 + 64 - lead - tz;
                cn = 6 + 64 - lead;
                cr = re ? 3 + 64 - int'(last_lead) : 1 << 30;
                if (cs <= cn && cs <= cr) flag = FLAG_STRIP;
                else if (re && cr < cn) flag = FLAG_REUSE;
                else flag = FLAG_NEW;
            end
            else
            begin
                flag = re ? FLAG_REUSE : FLAG_NEW;
            end
            if (flag == FLAG_STRIP)
            begin
                sig = 64 - lead - tz;
                push_chunk(64'(FLAG_STRIP) | (64'(code) << 3) | (64'(sig & 63) << 6), 12, 0);
                push_chunk(xp >> tz, sig, 1);
                last_lead = 7'(lead);
            end
            else if (flag == FLAG_REUSE)
            begin
                push_chunk(64'(FLAG_REUSE), 3, 0);
                push_chunk(xp, 64 - int'(last_lead), 1);
            end
            else
            begin
                push_chunk(64'(FLAG_NEW) | (64'(code) << 3), 6, 0);
                push_chunk(xp, 64 - lead, 1);
                last_lead = 7'(lead);
            end
        end
        last_value = v;
        ring_insert(v);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        chunk_count = 0;
        clear_history();
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                chunk_count++;
                if (chunk_queue.size() == 0)
                begin
                    report("unexpected chunk", result.chunk, '0);
                end
                else
                begin
                    want = chunk_queue.pop_front();
                    if (result.chunk !== want.chunk) report("chunk", result.chunk, want.chunk);
                    if (result.chunk_len !== want.chunk_len)
                        report("chunk_len", 64'(result.chunk_len), 64'(want.chunk_len));
                    if (result.last !== want.last)
                        report("last", 64'(result.last), 64'(want.last));
                end
            end
            if (sample_valid && !sample_stall) encode_sample(sample);
        end
    end
endmodule

// ----- tb/tb_chimp128_float_encoder.sv -----
// Testbench top for the Chimp128 float encoder: clock, reset, stimulus, verdict.
// Depends on chimp_pkg, chimp128_float_encoder and chimp128_float_encoder_checker.
`timescale 1ns / 100ps
module tb_chimp128_float_encoder;
    import chimp_pkg::*;

    logic clk;
    logic rst_n;
    in_t  sample;
    logic sample_valid;
    logic sample_stall;
    out_t result;
    logic result_valid;
    logic result_stall;
    int   errors;
    int   pending;
    int   chunk_count;
    bit   hold_off;
    bit   stall_on;
    int   sample_count;
    int   ready_gap;

    logic [63:0] base_values [8];

    chimp128_float_encoder uut (
        .clk(clk), .rst_n(rst_n),
        .sample(sample), .sample_valid(sample_valid), .sample_stall(sample_stall),
        .result(result), .result_valid(result_valid), .result_stall(result_stall)
    );

    chimp128_float_encoder_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .sample(sample), .sample_valid(sample_valid), .sample_stall(sample_stall),
        .result(result), .result_valid(result_valid), .result_stall(result_stall),
        .errors(errors), .pending(pending), .chunk_count(chunk_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic [63:0] v, bit st);
        int g;
        g = stall_on ? gap_len() : 0;
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample.value <= v;
        sample.start_req <= st;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        sample_count++;
    endtask

    function automatic logic [63:0] near_value();
        logic [63:0] v;
        int k;
        v = base_values[$urandom_range(0, 7)];
        case ($urandom_range(0, 5))
            0: v = v;
            1: v = v ^ 64'($urandom_range(1, 255));
            2: v = v ^ ({$urandom, $urandom} & ((64'd1 << $urandom_range(1, 52)) - 1));
            3:
            begin
                k = $urandom_range(0, 50);
                v = v ^ (64'($urandom_range(1, 8191)) << k);
            end
            4: v = v ^ {$urandom, $urandom};
            default: v = v ^ (64'd1 << $urandom_range(0, 63));
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (hold_off)
            result_stall <= 1'b1;
        else if (ready_gap > 0)
        begin
            result_stall <= 1'b1;
            ready_gap <= ready_gap - 1;
        end
        else if (stall_on)
        begin
            result_stall <= 1'b0;
            ready_gap <= gap_len();
        end
        else
            result_stall <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_chimp128_float_encoder failed");
        $finish;
    end

    initial
    begin
        int t;
        rst_n = 1'b0;
        sample = '0;
        sample_valid = 1'b0;
        hold_off = 0;
        stall_on = 0;
        sample_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no start after reset, extremes, repeats, ring hits
        send(64'h3FF0_0000_0000_0000, 0);
        send(64'h3FF0_0000_0000_0000, 0);
        send(64'hFFFF_FFFF_FFFF_FFFF, 1);
        send(64'h0000_0000_0000_0000, 0);
        send(64'h0000_0000_0000_0001, 0);
        send(64'h8000_0000_0000_0000, 0);
        send(64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(64'h4000_0000_0000_0000, 1);
        send(64'h4000_0000_0000_0100, 0);
        send(64'h4000_0000_0001_0000, 0);
        send(64'h4000_0000_0001_0000, 0);
        send(64'h4000_0000_0000_0100, 0);
        send(64'h4000_0000_0000_0103, 0);
        send(64'h4000_0000_0000_0107, 0);
        send(64'h4000_00F0_0000_0000, 0);
        send(64'h4000_0000_0000_0000, 0);
        send(64'h4000_0000_0000_0001, 0);
        send(64'h5555_5555_5555_5555, 0);
        send(64'hAAAA_AAAA_AAAA_AAAA, 0);
        send(64'h5555_5555_5555_5554, 0);
        send(64'h0000_0000_0000_0000, 1);

        // fill the output queue with the receiver held off
        hold_off = 1;
        fork
            begin
                repeat (120) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++) send(64'h3FF0_0000_0000_0000 + 64'(i * 3), 0);
        join
        stall_on = 1;

        for (int n = 0; n < 680; n++)
        begin
            if (n % 100 == 0)
            begin
                for (int b = 0; b < 8; b++) base_values[b] = {$urandom, $urandom};
                send(base_values[0], 1);
            end
            if (n == 300)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            t = $urandom_range(0, 19);
            if (t == 0) send({$urandom, $urandom}, 1);
            else if (t < 3) send({$urandom, $urandom}, 0);
            else send(near_value(), 0);
        end
        sample_valid <= 1'b0;
        @(posedge clk);

        t = 0;
        while (pending != 0 && t < 100000)
        begin
            @(posedge clk);
            t++;
        end
        repeat (20) @(posedge clk);
        $display("samples sent: %0d, chunks checked: %0d", sample_count, chunk_count);
        $display("covered raw starts, repeats, ring and previous coding under random stalls");
        if (errors == 0 && pending == 0)
            $display("tb_chimp128_float_encoder passed");
        else
            $display("tb_chimp128_float_encoder failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/chimp_pkg.sv
hdl/chimp_map.sv
hdl/chimp_ring.sv
hdl/chimp_oq.sv
hdl/chimp128_float_encoder.sv
tb/chimp128_float_encoder_checker.sv
tb/tb_chimp128_float_encoder.sv
